// ===== hw/rtl/rfpn_pkg.sv =====
// rfpn_pkg: widths, constants, tables and the output rounding function
// for the rotation-from-plane-normals datapath.
// Used by rfpn_div and rotation_from_plane_normals_unit.
`default_nettype none

package rfpn_pkg;

  // number formats
  localparam int InFracBits  = 20;
  localparam int OutFracBits = 16;
  localparam int WorkFrac    = 30;
  localparam int InW         = 32;
  localparam int OutW        = 18;
  localparam int OutShift    = WorkFrac - OutFracBits;

  // unit vector component, cross and dot terms in Q30
  localparam int CompW = 32;
  localparam int ProdW = 64;

  // matrix entry before output rounding
  localparam int EntW = 38;

  // square root: two radicand bits per stage
  localparam int SqrtSteps = 32;
  localparam int RemW      = 34;

  // divider: one quotient bit per stage
  localparam int DivNW  = 63;
  localparam int DivDW  = 32;
  localparam int DivQW  = 35;
  localparam int DivLat = DivQW + 1;

  // register count from accept to the output register
  localparam int PipeLat = 1 + (SqrtSteps + 1) + DivLat + 5 + DivLat + 1;

  // square of the constant third normal component
  localparam logic [ProdW-1:0] WSq = ProdW'(64'd1 << (2 * InFracBits));
  localparam logic [CompW-1:0] WMag = CompW'(64'd1 << InFracBits);

  // 1.0 in Q30 for the identity
  localparam logic signed [EntW-1:0] OneQ = EntW'(64'd1 << WorkFrac);

  // half of one output step, zero when no bits are dropped
  localparam logic [EntW:0] RoundHalf = (EntW + 1)'((64'd1 << OutShift) >> 1);
  localparam logic signed [EntW:0] OutMax = (EntW + 1)'((64'd1 << (OutW - 1)) - 1);
  localparam logic signed [EntW:0] OutMin = -(EntW + 1)'(64'd1 << (OutW - 1));

  // which of the six symmetric products c_i*c_j feeds each entry, row major
  localparam int PrIdx [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};

  // operand pairs of the six products
  localparam int PrA [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PrB [6] = '{0, 1, 2, 1, 2, 2};

  // side data that travels beside the entry dividers
  typedef struct packed {
    logic [2:0][CompW-1:0] c;
    logic [CompW-1:0]      k;
    logic                  deg;
    logic [5:0]            psg;
  } ent_side_t;

  // round a Q30 entry to the output step and saturate
  function automatic logic [OutW-1:0] pack_out(input logic signed [EntW-1:0] r);
    logic signed [EntW:0] t;
    logic signed [EntW:0] v;
    logic [OutW-1:0]      res;
    t = {r[EntW-1], r} + $signed(RoundHalf);
    v = t >>> OutShift;
    if (v > OutMax) begin
      res = OutMax[OutW-1:0];
    end else if (v < OutMin) begin
      res = OutMin[OutW-1:0];
    end else begin
      res = v[OutW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rotation_from_plane_normals_unit.sv =====
// rotation_from_plane_normals_unit: plane slopes of two views in, Rodrigues
// rotation matrix between the two plane normals out. Uses rfpn_pkg, rfpn_div.
//
//   channel   handshake             word
//   input     start / busy          first_slope_u/v_i, second_slope_u/v_i
//   result    valid_o (one cycle)   rot_00_o .. rot_22_o, degenerate_o
//
// One word enters per cycle; busy is never raised.
// The pipeline holds a 32-stage square root and two 35-stage dividers
// (unit normals, then matrix entries), plus multiply and round stages.
// Reset clears only the valid chain; words in flight are dropped.
// The receiver cannot stall: every result is shown for exactly one cycle.
`default_nettype none

module rotation_from_plane_normals_unit import rfpn_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic signed [InW-1:0] first_slope_u_i,
  input  wire logic signed [InW-1:0] first_slope_v_i,
  input  wire logic signed [InW-1:0] second_slope_u_i,
  input  wire logic signed [InW-1:0] second_slope_v_i,
  output logic                       valid_o,
  output logic signed [OutW-1:0]     rot_00_o,
  output logic signed [OutW-1:0]     rot_01_o,
  output logic signed [OutW-1:0]     rot_02_o,
  output logic signed [OutW-1:0]     rot_10_o,
  output logic signed [OutW-1:0]     rot_11_o,
  output logic signed [OutW-1:0]     rot_12_o,
  output logic signed [OutW-1:0]     rot_20_o,
  output logic signed [OutW-1:0]     rot_21_o,
  output logic signed [OutW-1:0]     rot_22_o,
  output logic                       degenerate_o
);

  logic accept;
  logic [PipeLat-1:0] vld_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeLat-2:0], accept};
    end
  end

  // input stage: slopes and their squares (au, av, bu, bv)
  logic signed [InW-1:0]   in_q [4];
  logic        [ProdW-1:0] sq_q [4];

  always_ff @(posedge clk_i) begin
    in_q[0] <= first_slope_u_i;
    in_q[1] <= first_slope_v_i;
    in_q[2] <= second_slope_u_i;
    in_q[3] <= second_slope_v_i;
    sq_q[0] <= ProdW'(first_slope_u_i * first_slope_u_i);
    sq_q[1] <= ProdW'(first_slope_v_i * first_slope_v_i);
    sq_q[2] <= ProdW'(second_slope_u_i * second_slope_u_i);
    sq_q[3] <= ProdW'(second_slope_v_i * second_slope_v_i);
  end

  // slopes ride beside the square roots
  logic signed [InW-1:0] cd_q [SqrtSteps+1][4];

  always_ff @(posedge clk_i) begin
    cd_q[0] <= in_q;
    for (int s = 0; s < SqrtSteps; s++) begin
      cd_q[s+1] <= cd_q[s];
    end
  end

  // vector lengths: digit-by-digit square root, two bits per stage
  logic [CompW-1:0] len [2];

  for (genvar n = 0; n < 2; n++) begin : g_sqrt
    logic [ProdW-1:0] sx_q   [SqrtSteps+1];
    logic [RemW-1:0]  srem_q [SqrtSteps+1];
    logic [CompW-1:0] root_q [SqrtSteps+1];

    always_ff @(posedge clk_i) begin
      sx_q[0]   <= sq_q[2*n] + sq_q[2*n+1] + WSq;
      srem_q[0] <= '0;
      root_q[0] <= '0;
    end

    for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
      logic [RemW+1:0] sh;
      logic [RemW+1:0] trial;
      logic            ge;
      assign sh    = {srem_q[s], sx_q[s][ProdW-1:ProdW-2]};
      assign trial = (RemW + 2)'({root_q[s], 2'b01});
      assign ge    = (sh >= trial);
      always_ff @(posedge clk_i) begin
        srem_q[s+1] <= ge ? RemW'(sh - trial) : sh[RemW-1:0];
        root_q[s+1] <= {root_q[s][CompW-2:0], ge};
        sx_q[s+1]   <= {sx_q[s][ProdW-3:0], 2'b00};
      end
    end

    assign len[n] = root_q[SqrtSteps];
  end

  // unit normals: |comp| * 2^30 / len, rounded half away from zero
  logic [5:0]       usg;
  logic [5:0]       usg_q [DivLat];
  logic [DivQW-1:0] uq [6];

  for (genvar e = 0; e < 6; e++) begin : g_udiv
    localparam int Vec = e / 3;
    localparam int Cmp = e % 3;
    logic [CompW-1:0] mag;
    logic [DivNW-1:0] dvd;
    if (Cmp == 2) begin : g_w
      assign mag    = WMag;
      assign usg[e] = 1'b1;
    end else begin : g_uv
      assign mag    = cd_q[SqrtSteps][2*Vec+Cmp][InW-1] ?
                      CompW'(-cd_q[SqrtSteps][2*Vec+Cmp]) :
                      CompW'(cd_q[SqrtSteps][2*Vec+Cmp]);
      assign usg[e] = cd_q[SqrtSteps][2*Vec+Cmp][InW-1];
    end
    assign dvd = DivNW'({mag, {WorkFrac{1'b0}}}) + DivNW'(len[Vec] >> 1);

    rfpn_div u_div (
      .clk_i (clk_i),
      .dvd_i (dvd),
      .dvs_i (len[Vec]),
      .quo_o (uq[e])
    );
  end

  always_ff @(posedge clk_i) begin
    usg_q[0] <= usg;
    for (int s = 0; s < DivLat - 1; s++) begin
      usg_q[s+1] <= usg_q[s];
    end
  end

  // signed unit components: a = 0..2, b = 3..5
  logic signed [CompW-1:0] un_q [6];

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 6; e++) begin
      un_q[e] <= usg_q[DivLat-1][e] ? -$signed(uq[e][CompW-1:0])
                                    : $signed(uq[e][CompW-1:0]);
    end
  end

  // cross and dot partial products in Q60
  logic signed [ProdW-1:0] m_q [9];

  always_ff @(posedge clk_i) begin
    m_q[0] <= un_q[1] * un_q[5];
    m_q[1] <= un_q[2] * un_q[4];
    m_q[2] <= un_q[2] * un_q[3];
    m_q[3] <= un_q[0] * un_q[5];
    m_q[4] <= un_q[0] * un_q[4];
    m_q[5] <= un_q[1] * un_q[3];
    m_q[6] <= un_q[0] * un_q[3];
    m_q[7] <= un_q[1] * un_q[4];
    m_q[8] <= un_q[2] * un_q[5];
  end

  // cross product, dot product, parallel test
  logic signed [ProdW-1:0] x_q [3];
  logic signed [ProdW-1:0] dot_q;
  logic                    deg_s_q;
  logic signed [ProdW-1:0] x_d [3];

  always_comb begin
    x_d[0] = m_q[0] - m_q[1];
    x_d[1] = m_q[2] - m_q[3];
    x_d[2] = m_q[4] - m_q[5];
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    dot_q   <= m_q[6] + m_q[7] + m_q[8];
    deg_s_q <= (x_d[0] == '0) && (x_d[1] == '0) && (x_d[2] == '0);
  end

  // back to Q30; denominator 1 + cos folded into one rounding add
  localparam logic signed [ProdW-1:0] HalfWork = ProdW'(64'd1 << (WorkFrac - 1));
  localparam logic signed [ProdW-1:0] DenBias  =
    ProdW'((64'd1 << (2 * WorkFrac)) + (64'd1 << (WorkFrac - 1)));

  logic signed [CompW-1:0] c_q [3];
  logic signed [CompW-1:0] k_q;
  logic        [DivDW-1:0] den_q;
  logic                    deg_r_q;
  logic signed [ProdW-1:0] den_full;

  assign den_full = (dot_q + DenBias) >>> WorkFrac;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      c_q[i] <= CompW'((x_q[i] + HalfWork) >>> WorkFrac);
    end
    k_q     <= CompW'((dot_q + HalfWork) >>> WorkFrac);
    den_q   <= (den_full < 1) ? DivDW'(1) : DivDW'(den_full);
    deg_r_q <= deg_s_q;
  end

  // symmetric products c_i * c_j
  logic signed [ProdW-1:0] p_q [6];
  logic signed [CompW-1:0] c_p_q [3];
  logic signed [CompW-1:0] k_p_q;
  logic        [DivDW-1:0] den_p_q;
  logic                    deg_p_q;

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 6; e++) begin
      p_q[e] <= c_q[PrA[e]] * c_q[PrB[e]];
    end
    c_p_q   <= c_q;
    k_p_q   <= k_q;
    den_p_q <= den_q;
    deg_p_q <= deg_r_q;
  end

  // entry dividers: |c_i c_j| / (1 + cos), rounded half away from zero
  logic [DivQW-1:0] eq [6];
  logic [5:0]       psg;
  ent_side_t        side;
  ent_side_t        side_q [DivLat];

  for (genvar e = 0; e < 6; e++) begin : g_ediv
    logic [ProdW-1:0] pmag;
    logic [DivNW-1:0] dvd;
    assign pmag   = p_q[e][ProdW-1] ? ProdW'(-p_q[e]) : ProdW'(p_q[e]);
    assign dvd    = pmag[DivNW-1:0] + DivNW'(den_p_q >> 1);
    assign psg[e] = p_q[e][ProdW-1];

    rfpn_div u_div (
      .clk_i (clk_i),
      .dvd_i (dvd),
      .dvs_i (den_p_q),
      .quo_o (eq[e])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side.c[i] = c_p_q[i];
    end
    side.k   = k_p_q;
    side.deg = deg_p_q;
    side.psg = psg;
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side;
    for (int s = 0; s < DivLat - 1; s++) begin
      side_q[s+1] <= side_q[s];
    end
  end

  // assemble entries: quotient, cos on the diagonal, skew part off it
  ent_side_t              so;
  logic signed [EntW-1:0] r   [9];
  logic signed [EntW-1:0] ce  [3];
  logic signed [EntW-1:0] ke;
  logic        [OutW-1:0] rot_d [9];

  assign so = side_q[DivLat-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ce[i] = EntW'($signed(so.c[i]));
    end
    ke = EntW'($signed(so.k));
    for (int e = 0; e < 9; e++) begin
      r[e] = so.psg[PrIdx[e]] ? -$signed(EntW'(eq[PrIdx[e]]))
                              : $signed(EntW'(eq[PrIdx[e]]));
    end
    r[0] = r[0] + ke;
    r[4] = r[4] + ke;
    r[8] = r[8] + ke;
    r[1] = r[1] - ce[2];
    r[2] = r[2] + ce[1];
    r[3] = r[3] + ce[2];
    r[5] = r[5] - ce[0];
    r[6] = r[6] - ce[1];
    r[7] = r[7] + ce[0];
    for (int e = 0; e < 9; e++) begin
      if (so.deg) begin
        rot_d[e] = pack_out((e % 4 == 0) ? OneQ : '0);
      end else begin
        rot_d[e] = pack_out(r[e]);
      end
    end
  end

  // output register
  logic [OutW-1:0] rot_q [9];
  logic            deg_o_q;

  always_ff @(posedge clk_i) begin
    rot_q   <= rot_d;
    deg_o_q <= so.deg;
  end

  assign valid_o      = vld_q[PipeLat-1];
  assign degenerate_o = deg_o_q;
  assign rot_00_o     = $signed(rot_q[0]);
  assign rot_01_o     = $signed(rot_q[1]);
  assign rot_02_o     = $signed(rot_q[2]);
  assign rot_10_o     = $signed(rot_q[3]);
  assign rot_11_o     = $signed(rot_q[4]);
  assign rot_12_o     = $signed(rot_q[5]);
  assign rot_20_o     = $signed(rot_q[6]);
  assign rot_21_o     = $signed(rot_q[7]);
  assign rot_22_o     = $signed(rot_q[8]);

  // every accepted word comes out after the full pipeline latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PipeLat valid_o)
    else $error("accepted word did not produce a result");

  // no result without an accepted word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, PipeLat))
    else $error("result without an accepted word");

  // parallel normals give the identity: rot_01, rot_12 and rot_20 are zero
  a_deg_offdiag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && degenerate_o) |-> (rot_01_o == '0 && rot_12_o == '0 && rot_20_o == '0))
    else $error("degenerate result has nonzero off-diagonal");

  // parallel normals give the identity: equal diagonal
  a_deg_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && degenerate_o) |-> (rot_00_o == rot_11_o && rot_11_o == rot_22_o))
    else $error("degenerate result has unequal diagonal");

endmodule

`default_nettype wire

// ===== hw/rtl/rfpn_div.sv =====
// rfpn_div: pipelined restoring divider, one quotient bit per stage,
// quotient saturates to all ones when it would not fit. Uses rfpn_pkg.
`default_nettype none

module rfpn_div import rfpn_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic [DivNW-1:0] dvd_i,
  input  wire logic [DivDW-1:0] dvs_i,
  output logic      [DivQW-1:0] quo_o
);

  logic [DivDW-1:0] rem_q [DivLat];
  logic [DivDW-1:0] dvs_q [DivLat];
  logic [DivQW-1:0] lo_q  [DivLat];
  logic [DivQW-1:0] quo_q [DivLat];
  logic             ovf_q [DivLat];

  // entry: upper dividend bits form the first partial remainder
  always_ff @(posedge clk_i) begin
    rem_q[0] <= DivDW'(dvd_i[DivNW-1:DivQW]);
    lo_q[0]  <= dvd_i[DivQW-1:0];
    dvs_q[0] <= dvs_i;
    quo_q[0] <= '0;
    ovf_q[0] <= (DivDW'(dvd_i[DivNW-1:DivQW]) >= dvs_i);
  end

  // one compare and subtract per stage
  for (genvar s = 0; s < DivQW; s++) begin : g_stage
    logic [DivDW:0] sh;
    logic           ge;
    assign sh = {rem_q[s], lo_q[s][DivQW-1]};
    assign ge = (sh >= {1'b0, dvs_q[s]});
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= ge ? DivDW'(sh - {1'b0, dvs_q[s]}) : sh[DivDW-1:0];
      lo_q[s+1]  <= {lo_q[s][DivQW-2:0], 1'b0};
      dvs_q[s+1] <= dvs_q[s];
      quo_q[s+1] <= {quo_q[s][DivQW-2:0], ge};
      ovf_q[s+1] <= ovf_q[s];
    end
  end

  assign quo_o = ovf_q[DivQW] ? '1 : quo_q[DivQW];

endmodule

`default_nettype wire
